// ===== hw/rtl/rsort_pkg.sv =====
// ----------------------------------------------------------------------------
// rsort_pkg
// shared constants for the row ascending sorter
// ----------------------------------------------------------------------------
package rsort_pkg;

    // words in one row
    localparam int ROW_LENGTH = 8;
    // index width into the row store
    localparam int IDX_W      = $clog2(ROW_LENGTH);
    // element width
    localparam int DATA_W     = 32;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic signed [DATA_W-1:0] t_elem;

    localparam t_idx LAST_IDX = t_idx'(ROW_LENGTH - 1);

endpackage

// ===== hw/rtl/row_ascending_sorter.sv =====
// ----------------------------------------------------------------------------
// row_ascending_sorter
// collects one row of signed words, sorts it ascending by exchanges within the row
// store and sends the row out smallest first, last word flagged
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------
//  in      | i_in_valid / o_in_stall  | i_element_value (s32)
//  out     | o_out_valid / i_out_stall| o_sorted_value (s32), o_row_last
//
//  a row of N words is loaded first; then each pass i fetches entry i,
//  compares the held word with entries i+1 to N-1 and emits the smallest;
//  the single read port of the row store, one compare per cycle, sets the
//  pace of the sort
//  reset clears the sequencer and the output valid flag; the store needs no
//  clearing since each entry is written before it is read
//  a stalled output holds the sequencer in its emit cycle; input is stalled
//  from the last word of a row until the last sorted word is loaded
// ----------------------------------------------------------------------------
module row_ascending_sorter
    import rsort_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_element_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_sorted_value,
    output logic        o_row_last
);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_FIRST = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]  r_state, n_state;
    t_idx        r_fill, n_fill;
    t_idx        r_i, n_i;
    t_idx        r_k, n_k;
    t_elem       r_ri, n_ri;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_sorted_value, n_sorted_value;
    logic        r_row_last, n_row_last;

    logic        w_wr_en;
    t_idx        w_wr_addr;
    logic [31:0] w_wr_data;
    t_idx        w_rd_addr;
    logic [31:0] w_rd_data;
    logic        w_in_acc;
    logic        w_out_free;

    assign w_in_acc   = i_in_valid && (r_state == ST_LOAD);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // row store
    rsort_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ROW_LENGTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // sort sequencer: load, fetch pivot, compare-exchange, emit minimum
    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_i            = r_i;
        n_k            = r_k;
        n_ri           = r_ri;
        n_out_valid    = r_out_valid && i_out_stall;
        n_sorted_value = r_sorted_value;
        n_row_last     = r_row_last;
        w_wr_en        = 1'b0;
        w_wr_addr      = r_fill;
        w_wr_data      = i_element_value;
        w_rd_addr      = '0;
        case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    w_wr_en = 1'b1;
                    if (r_fill == LAST_IDX) begin
                        n_fill    = '0;
                        n_i       = '0;
                        w_rd_addr = '0;
                        n_state   = ST_FIRST;
                    end else begin
                        n_fill = r_fill + t_idx'(1);
                    end
                end
            end
            ST_FIRST: begin
                n_ri = $signed(w_rd_data);
                if (r_i == LAST_IDX) begin
                    n_state = ST_EMIT;
                end else begin
                    n_k       = r_i + t_idx'(1);
                    w_rd_addr = r_i + t_idx'(1);
                    n_state   = ST_CMP;
                end
            end
            ST_CMP: begin
                // exchange when the held word is greater than entry k
                if (r_ri > $signed(w_rd_data)) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_k;
                    w_wr_data = r_ri;
                    n_ri      = $signed(w_rd_data);
                end
                if (r_k == LAST_IDX) begin
                    n_state = ST_EMIT;
                end else begin
                    n_k       = r_k + t_idx'(1);
                    w_rd_addr = r_k + t_idx'(1);
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_sorted_value = r_ri;
                    n_row_last     = (r_i == LAST_IDX);
                    if (r_i == LAST_IDX) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_i       = r_i + t_idx'(1);
                        w_rd_addr = r_i + t_idx'(1);
                        n_state   = ST_FIRST;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_fill      <= '0;
            r_i         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_i         <= n_i;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ri           <= n_ri;
        r_sorted_value <= n_sorted_value;
        r_row_last     <= n_row_last;
    end

    assign o_in_stall     = (r_state != ST_LOAD);
    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_sorted_value;
    assign o_row_last     = r_row_last;

endmodule

// ===== hw/rtl/rsort_ram.sv =====
// ----------------------------------------------------------------------------
// rsort_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rsort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/rsort_checker.sv =====
// ----------------------------------------------------------------------------
// rsort_checker
// port-level checks on the row ascending sorter, bound to the top level
// ----------------------------------------------------------------------------
module rsort_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_sorted_value,
    input logic        o_row_last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sorted_value)
            && $stable(o_row_last))
        else $error("output word changed while stalled");

    // while a word before the row end is shown the sorter is still busy
    a_busy_mid_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_row_last |-> o_in_stall)
        else $error("input open while a row is still being sent");

    // input closes only right after a word was accepted
    a_stall_after_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stalled without a word taken");

    // input reopens only together with the last word of a row
    a_reopen_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid && o_row_last)
        else $error("input reopened before the row end was sent");

endmodule

bind row_ascending_sorter rsort_checker u_rsort_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_sorted_value (o_sorted_value),
    .o_row_last     (o_row_last)
);
